[hdl/qvr_pkg.sv]
// Shared widths, mode codes and pipeline types for the quaternion vector rotator.
package qvr_pkg;

  localparam int QW    = 18;           // quaternion part, Q3.15
  localparam int VW    = 32;           // vector part, Q16.16
  localparam int PW    = 36;           // part products, Q.30
  localparam int EW    = 38;           // matrix entries, Q.30
  localparam int LW    = 37;           // squared norm, Q.30
  localparam int SPLIT = 19;           // low slice of an entry for the split multiply
  localparam int PLW   = VW + SPLIT + 1;
  localparam int PHW   = VW + EW - SPLIT;
  localparam int TW    = 71;           // axis sum, Q.46
  localparam int MW    = 70;           // magnitude of an axis sum
  localparam int DENW  = 73;           // divisor, up to |q|^4 = 2^72
  localparam int NW    = 101;          // dividend m*2^shift + den
  localparam int DW    = DENW + 1;     // doubled divisor
  localparam int QBW   = 32;           // quotient bits
  localparam int CW    = DW + QBW;     // compare width for shifted divisor

  localparam int BASE_SHIFT = 1;
  localparam int INV_SHIFT  = 31;

  // 1.0 in Q.30: divisor of the plain rotate modes
  localparam logic [DENW-1:0] DEN_UNIT = DENW'(1) << 30;

  localparam logic [QBW-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [QBW-1:0] LIM_NEG = 32'h8000_0000;

  localparam logic [2:0] MODE_ROT       = 3'd0;
  localparam logic [2:0] MODE_CONJ      = 3'd1;
  localparam logic [2:0] MODE_DIV2      = 3'd2;
  localparam logic [2:0] MODE_DIV2_CONJ = 3'd3;
  localparam logic [2:0] MODE_INV       = 3'd4;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [QW-1:0] quat_i;
    logic signed [QW-1:0] quat_j;
    logic signed [QW-1:0] quat_k;
    logic signed [QW-1:0] quat_r;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic [2:0][TW-1:0] t;
    logic [DENW-1:0]    den;
    logic               inv;
    logic               kill;
  } qvr_sum_t;

  typedef struct packed {
    logic [DW-1:0]       den2;
    logic                kill;
    logic [2:0]          neg;
    logic [2:0]          ovf;
    logic [2:0][NW-1:0]  rem;
    logic [2:0][QBW-1:0] quo;
  } qvr_div_t;

  typedef struct packed {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 saturated;
  } qvr_res_t;

endpackage

[hdl/qvr_if.sv]
// Valid/ready channel interfaces for the rotator input and result words.
interface qvr_in_if import qvr_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic signed [QW-1:0] quat_i;
  logic signed [QW-1:0] quat_j;
  logic signed [QW-1:0] quat_k;
  logic signed [QW-1:0] quat_r;
  logic signed [VW-1:0] vec_x;
  logic signed [VW-1:0] vec_y;
  logic signed [VW-1:0] vec_z;

  modport source (
    output valid, mode, quat_i, quat_j, quat_k, quat_r, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, mode, quat_i, quat_j, quat_k, quat_r, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if import qvr_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] out_x;
  logic signed [VW-1:0] out_y;
  logic signed [VW-1:0] out_z;
  logic                 saturated;

  modport source (
    output valid, out_x, out_y, out_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated,
    output ready
  );
endinterface

[hdl/qvr_matrix.sv]
// Rotation matrix build and matrix-vector product, five register stages.
module qvr_matrix import qvr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  qvr_in_t  item_i,
  output logic     valid_o,
  output qvr_sum_t sum_o
);

  localparam int XX = 0, YY = 1, ZZ = 2, WW = 3, YZ = 4;
  localparam int ZX = 5, XY = 6, WX = 7, WY = 8, WZ = 9;

  logic [4:0] vld_q;

  // stage 1: part products
  logic signed [QW:0]   w_ext, w_eff;
  logic                 conj;
  logic signed [PW-1:0] pr_d [10];
  logic signed [PW-1:0] pr_q [10];
  logic signed [VW-1:0] v1_d [3];
  logic signed [VW-1:0] v1_q [3];
  logic [2:0]           mode1_q;

  // stage 2: matrix entries and norm
  logic signed [EW-1:0] e_d [9];
  logic signed [EW-1:0] e_q [9];
  logic [LW-1:0]        ll_d, ll_q;
  logic signed [VW-1:0] v2_q [3];
  logic [2:0]           mode2_q;

  // stage 3: split products
  logic signed [PLW-1:0] pl_d [9];
  logic signed [PLW-1:0] pl_q [9];
  logic signed [PHW-1:0] ph_d [9];
  logic signed [PHW-1:0] ph_q [9];
  logic [SPLIT-1:0]      al;
  logic [LW-SPLIT-1:0]   ah;
  logic [2*SPLIT-1:0]    al2_d, al2_q;
  logic [LW-1:0]         ahal_d, ahal_q;
  logic [2*(LW-SPLIT)-1:0] ah2_d, ah2_q;
  logic [LW-1:0]         ll3_q;
  logic [2:0]            mode3_q;

  // stage 4: full products and divisor
  logic signed [TW-1:0] p_d [9];
  logic signed [TW-1:0] p_q [9];
  logic [DENW-1:0]      ll2;
  logic [DENW-1:0]      den_d, den4_q;
  logic                 inv_d, inv4_q;

  // stage 5: axis sums
  logic signed [TW-1:0] t_d [3];
  qvr_sum_t             sum_q;

  always_comb begin
    conj = (item_i.mode == MODE_CONJ) || (item_i.mode == MODE_DIV2_CONJ) ||
           (item_i.mode == MODE_INV);
    w_ext = {item_i.quat_r[QW-1], item_i.quat_r};
    w_eff = conj ? -w_ext : w_ext;
    pr_d[XX] = item_i.quat_i * item_i.quat_i;
    pr_d[YY] = item_i.quat_j * item_i.quat_j;
    pr_d[ZZ] = item_i.quat_k * item_i.quat_k;
    pr_d[WW] = item_i.quat_r * item_i.quat_r;
    pr_d[YZ] = item_i.quat_j * item_i.quat_k;
    pr_d[ZX] = item_i.quat_k * item_i.quat_i;
    pr_d[XY] = item_i.quat_i * item_i.quat_j;
    pr_d[WX] = w_eff * item_i.quat_i;
    pr_d[WY] = w_eff * item_i.quat_j;
    pr_d[WZ] = w_eff * item_i.quat_k;
    v1_d[0]  = item_i.vec_x;
    v1_d[1]  = item_i.vec_y;
    v1_d[2]  = item_i.vec_z;
  end

  always_comb begin
    e_d[0] = EW'(pr_q[WW]) + EW'(pr_q[XX]) - EW'(pr_q[YY]) - EW'(pr_q[ZZ]);
    e_d[1] = (EW'(pr_q[XY]) - EW'(pr_q[WZ])) <<< 1;
    e_d[2] = (EW'(pr_q[ZX]) + EW'(pr_q[WY])) <<< 1;
    e_d[3] = (EW'(pr_q[XY]) + EW'(pr_q[WZ])) <<< 1;
    e_d[4] = EW'(pr_q[WW]) - EW'(pr_q[XX]) + EW'(pr_q[YY]) - EW'(pr_q[ZZ]);
    e_d[5] = (EW'(pr_q[YZ]) - EW'(pr_q[WX])) <<< 1;
    e_d[6] = (EW'(pr_q[ZX]) - EW'(pr_q[WY])) <<< 1;
    e_d[7] = (EW'(pr_q[YZ]) + EW'(pr_q[WX])) <<< 1;
    e_d[8] = EW'(pr_q[WW]) - EW'(pr_q[XX]) - EW'(pr_q[YY]) + EW'(pr_q[ZZ]);
    ll_d   = LW'($unsigned(pr_q[XX])) + LW'($unsigned(pr_q[YY])) +
             LW'($unsigned(pr_q[ZZ])) + LW'($unsigned(pr_q[WW]));
  end

  // entry = hi * 2^19 + lo, two narrow multiplies per entry
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pl_d[r*3+c] = v2_q[c] * $signed({1'b0, e_q[r*3+c][SPLIT-1:0]});
        ph_d[r*3+c] = v2_q[c] * $signed(e_q[r*3+c][EW-1:SPLIT]);
      end
    end
    al     = ll_q[SPLIT-1:0];
    ah     = ll_q[LW-1:SPLIT];
    al2_d  = al * al;
    ahal_d = ah * al;
    ah2_d  = ah * ah;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p_d[i] = (TW'(ph_q[i]) <<< SPLIT) + TW'(pl_q[i]);
    end
    ll2 = (DENW'(ah2_q) << (2*SPLIT)) + (DENW'(ahal_q) << (SPLIT+1)) + DENW'(al2_q);
    inv_d = 1'b0;
    unique case (mode3_q)
      MODE_ROT, MODE_CONJ:       den_d = DEN_UNIT;
      MODE_DIV2, MODE_DIV2_CONJ: den_d = DENW'(ll3_q);
      MODE_INV: begin
        den_d = ll2;
        inv_d = 1'b1;
      end
      default:                   den_d = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t_d[r] = p_q[r*3] + p_q[r*3+1] + p_q[r*3+2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q    <= pr_d;
      v1_q    <= v1_d;
      mode1_q <= item_i.mode;
      e_q     <= e_d;
      ll_q    <= ll_d;
      v2_q    <= v1_q;
      mode2_q <= mode1_q;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      al2_q   <= al2_d;
      ahal_q  <= ahal_d;
      ah2_q   <= ah2_d;
      ll3_q   <= ll_q;
      mode3_q <= mode2_q;
      p_q     <= p_d;
      den4_q  <= den_d;
      inv4_q  <= inv_d;
      for (int r = 0; r < 3; r++) begin
        sum_q.t[r] <= t_d[r];
      end
      sum_q.den  <= den4_q;
      sum_q.inv  <= inv4_q;
      sum_q.kill <= (den4_q == '0);
    end
  end

  assign valid_o = vld_q[4];
  assign sum_o   = sum_q;

endmodule

[hdl/qvr_div_step.sv]
// One restoring division step for all three axes, registered.
module qvr_div_step import qvr_pkg::*; #(
  parameter int unsigned SH = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  qvr_div_t d_i,
  output logic     valid_o,
  output qvr_div_t d_o
);

  logic [CW-1:0] dsh;
  qvr_div_t      d_d, d_q;
  logic          vld_q;

  always_comb begin
    dsh = CW'(d_i.den2) << SH;
    d_d = d_i;
    for (int a = 0; a < 3; a++) begin
      if (CW'(d_i.rem[a]) >= dsh) begin
        d_d.rem[a]     = d_i.rem[a] - NW'(dsh);
        d_d.quo[a][SH] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = vld_q;
  assign d_o     = d_q;

endmodule

[hdl/qvr_divider.sv]
// Rounding divider: dividend prep, overflow check, 32 step stages, saturation.
module qvr_divider import qvr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  qvr_sum_t sum_i,
  output logic     valid_o,
  output qvr_res_t res_o
);

  logic signed [TW-1:0] ts [3];
  logic [MW-1:0]        mag [3];
  logic [2:0]           neg_d;
  logic [NW-1:0]        n_d [3];
  logic [NW-1:0]        n_q [3];
  logic [2:0]           neg_q;
  logic [DW-1:0]        d2_q;
  logic                 kill_q;
  logic                 vp_q;

  qvr_div_t             pre_d, pre_q;
  logic                 vo_q;

  qvr_div_t             stg [QBW+1];
  logic                 svld [QBW+1];

  logic [QBW-1:0]       lim [3];
  logic [QBW-1:0]       mv  [3];
  logic [QBW-1:0]       ov  [3];
  logic [2:0]           sat;

  // magnitude and dividend m*2^shift + den (round half away from zero)
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ts[a]    = $signed(sum_i.t[a]);
      neg_d[a] = ts[a][TW-1];
      mag[a]   = MW'(neg_d[a] ? -ts[a] : ts[a]);
      n_d[a]   = (NW'(mag[a]) << (sum_i.inv ? INV_SHIFT : BASE_SHIFT)) + NW'(sum_i.den);
    end
  end

  // quotient must fit 32 bits, else clip
  always_comb begin
    pre_d.den2 = d2_q;
    pre_d.kill = kill_q;
    pre_d.neg  = neg_q;
    for (int a = 0; a < 3; a++) begin
      pre_d.ovf[a] = CW'(n_q[a]) >= (CW'(d2_q) << QBW);
      pre_d.rem[a] = n_q[a];
      pre_d.quo[a] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      neg_q  <= neg_d;
      d2_q   <= DW'(sum_i.den) << 1;
      kill_q <= sum_i.kill;
      pre_q  <= pre_d;
    end
  end

  assign stg[0]  = pre_q;
  assign svld[0] = vo_q;

  for (genvar s = 0; s < QBW; s++) begin : g_step
    qvr_div_step #(.SH(QBW - 1 - s)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (svld[s]),
      .d_i     (stg[s]),
      .valid_o (svld[s+1]),
      .d_o     (stg[s+1])
    );
  end

  // clip to Q16.16 and restore sign
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = stg[QBW].neg[a] ? LIM_NEG : LIM_POS;
      sat[a] = !stg[QBW].kill && (stg[QBW].ovf[a] || (stg[QBW].quo[a] > lim[a]));
      mv[a]  = sat[a] ? lim[a] : stg[QBW].quo[a];
      ov[a]  = stg[QBW].kill ? '0 : (stg[QBW].neg[a] ? -mv[a] : mv[a]);
    end
    res_o.out_x     = $signed(ov[0]);
    res_o.out_y     = $signed(ov[1]);
    res_o.out_z     = $signed(ov[2]);
    res_o.saturated = |sat;
  end

  assign valid_o = svld[QBW];

endmodule

[hdl/quaternion_vector_rotate.sv]
// Top level of the pipelined quaternion vector rotator.
//
// Input channel in_i takes one word per cycle unless stalled: a mode, a
// quaternion in signed Q3.15 and a vector in signed Q16.16. Output
// channel out_o gives the rotated vector in signed Q16.16 plus a
// saturated flag, one word per input word, in order. A word is taken
// when valid and ready are both high. Modes: rotate, conjugate rotate,
// each divided by |q|^2, and conjugate rotate divided by |q|^4. A zero
// quaternion in a dividing mode, or an undefined mode, gives a zero
// vector without the flag. Stages: five matrix, two divider prep, 32
// quotient-bit and the output register. Throughput is one word per
// cycle unless stalled; the 32-stage restoring divider sets the depth.
// Reset clears only the valid bits; the pipe then runs empty.
// When the receiver holds ready low with a word waiting, the whole pipe
// freezes and in_i.ready drops in the same cycle; nothing is lost.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qvr_in_if.sink    in_i,
  qvr_out_if.source out_o
);

  logic     en;
  qvr_in_t  item;
  logic     mat_vld;
  qvr_sum_t mat_sum;
  logic     div_vld;
  qvr_res_t div_res;
  logic     out_valid_q;
  qvr_res_t res_q;

  // global advance: stall only while a result sits unclaimed
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    item.mode   = in_i.mode;
    item.quat_i = in_i.quat_i;
    item.quat_j = in_i.quat_j;
    item.quat_k = in_i.quat_k;
    item.quat_r = in_i.quat_r;
    item.vec_x  = in_i.vec_x;
    item.vec_y  = in_i.vec_y;
    item.vec_z  = in_i.vec_z;
  end

  qvr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (mat_vld),
    .sum_o   (mat_sum)
  );

  qvr_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_vld),
    .sum_i   (mat_sum),
    .valid_o (div_vld),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= div_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = res_q.out_x;
  assign out_o.out_y     = res_q.out_y;
  assign out_o.out_z     = res_q.out_z;
  assign out_o.saturated = res_q.saturated;

endmodule
